>>> sv/assert_macros.svh
// Assertion macros shared by the packet header parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PHP_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("packet_header_parser assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PHP_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("packet_header_parser assertion failed");

`endif

>>> sv/php_pkg.sv
// Types, constants and helpers for the packet header parser.
`default_nettype none
package php_pkg;
	localparam int POS_W = 16;
	localparam int MAX_POSITION_DEF = 65535;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [1:0] LINK_ETH  = 2'd0;
	localparam logic [1:0] LINK_SLL  = 2'd1;
	localparam logic [1:0] LINK_RAW  = 2'd2;
	localparam logic [1:0] LINK_NONE = 2'd3;

	localparam logic [15:0] ETHERTYPE_V4 = 16'h0800;
	localparam logic [15:0] ETHERTYPE_V6 = 16'h86DD;

	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] PROTO_SCTP = 8'd132;
	localparam logic [7:0] PROTO_DCCP = 8'd33;

	localparam logic [1:0] NK_NONE = 2'd0;
	localparam logic [1:0] NK_V4   = 2'd1;
	localparam logic [1:0] NK_V6   = 2'd2;

	localparam logic [2:0] TK_NONE = 3'd0;
	localparam logic [2:0] TK_TCP  = 3'd1;
	localparam logic [2:0] TK_UDP  = 3'd2;
	localparam logic [2:0] TK_SCTP = 3'd3;
	localparam logic [2:0] TK_DCCP = 3'd4;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [31:0] packet_tag;
	} byte_item_t;

	typedef struct packed {
		logic        recognized;
		logic        ethernet_seen;
		logic [1:0]  network_kind;
		logic [2:0]  transport_kind;
		logic        endpoints_valid;
		logic [63:0] source_high;
		logic [63:0] source_low;
		logic [63:0] destination_high;
		logic [63:0] destination_low;
		logic [15:0] source_port;
		logic [15:0] destination_port;
		logic [31:0] result_tag;
	} record_t;

	function automatic logic [1:0] ip_version(input logic [1:0] lt, input logic [15:0] ek,
		input logic [3:0] vn);
		logic [1:0] v;
		v = NK_NONE;
		case (lt)
			LINK_ETH, LINK_SLL: begin
				if (ek == ETHERTYPE_V4) v = NK_V4;
				else if (ek == ETHERTYPE_V6) v = NK_V6;
			end
			LINK_RAW: begin
				if (vn == 4'd4) v = NK_V4;
				else if (vn == 4'd6) v = NK_V6;
			end
			default: v = NK_NONE;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

>>> sv/php_front.sv
// Front end: captures header fields by byte position and builds the record.
`default_nettype none
module php_front #(
	parameter int MAX_POSITION = php_pkg::MAX_POSITION_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         link_type,
	input  wire logic               take,
	input  wire php_pkg::byte_item_t item,
	output php_pkg::record_t        rec
);
	logic [php_pkg::POS_W-1:0] pos_q;
	logic [15:0] ek_q, ek_n;
	logic [3:0]  vn_q, vn_n, hw_q, hw_n;
	logic [7:0]  np_q, np_n;
	logic [63:0] ad_q [4];
	logic [63:0] ad_n [4];
	logic [15:0] pt_q [2];
	logic [15:0] pt_n [2];

	logic [16:0] p, o, l4c, d, len, l4f, need;
	logic [7:0]  b;
	logic [1:0]  v, vf, ai;
	logic [5:0]  k;
	logic        ok, ev;
	logic [2:0]  tk;

	always_comb begin
		b = item.data_byte;
		p = {1'b0, pos_q};
		ek_n = ek_q;
		vn_n = vn_q;
		hw_n = hw_q;
		np_n = np_q;
		ad_n = ad_q;
		pt_n = pt_q;
		v = php_pkg::NK_NONE;
		l4c = '0;
		d = '0;
		k = '0;
		ai = '0;
		case (link_type)
			php_pkg::LINK_ETH: o = 17'd14;
			php_pkg::LINK_SLL: o = 17'd16;
			default: o = 17'd0;
		endcase
		if (link_type == php_pkg::LINK_ETH && p == 17'd12) ek_n = {b, 8'h00};
		if (link_type == php_pkg::LINK_ETH && p == 17'd13) ek_n = {ek_q[15:8], b};
		if (link_type == php_pkg::LINK_SLL && p == 17'd14) ek_n = {b, 8'h00};
		if (link_type == php_pkg::LINK_SLL && p == 17'd15) ek_n = {ek_q[15:8], b};
		if (link_type != php_pkg::LINK_NONE) begin
			if (p == o) begin
				vn_n = b[7:4];
				hw_n = b[3:0];
			end else if (p > o) begin
				v = php_pkg::ip_version(link_type, ek_n, vn_q);
				if (v == php_pkg::NK_V4) begin
					if (p == o + 17'd9) np_n = b;
					else if (p >= o + 17'd12 && p < o + 17'd16) ad_n[1] = {ad_q[1][55:0], b};
					else if (p >= o + 17'd16 && p < o + 17'd20) ad_n[3] = {ad_q[3][55:0], b};
					l4c = o + {11'd0, hw_q, 2'b00};
				end else if (v == php_pkg::NK_V6) begin
					k = p[5:0] - o[5:0];
					if ((p - o) == 17'd6) np_n = b;
					else if ((p - o) >= 17'd8 && (p - o) < 17'd40) begin
						ai = 2'((k - 6'd8) >> 3);
						ad_n[ai] = {ad_q[ai][55:0], b};
					end
					l4c = o + 17'd40;
				end
				d = p - l4c;
				if ((v == php_pkg::NK_V6 || (v == php_pkg::NK_V4 && hw_q >= 4'd5)) && p >= l4c) begin
					if (d < 17'd2) pt_n[0] = {pt_q[0][7:0], b};
					else if (d < 17'd4) pt_n[1] = {pt_q[1][7:0], b};
				end
			end
		end
	end

	always_comb begin
		len = p + 17'd1;
		vf = php_pkg::ip_version(link_type, ek_n, vn_n);
		ok = (link_type == php_pkg::LINK_ETH && len >= 17'd14) ||
			(link_type == php_pkg::LINK_SLL && len >= 17'd16) ||
			(link_type == php_pkg::LINK_RAW);
		rec = '0;
		rec.result_tag = item.packet_tag;
		rec.ethernet_seen = (link_type == php_pkg::LINK_ETH && len >= 17'd14);
		rec.recognized = rec.ethernet_seen;
		ev = 1'b0;
		l4f = '0;
		need = '0;
		tk = php_pkg::TK_NONE;
		if (ok) begin
			if (vf == php_pkg::NK_V4 && len >= o + 17'd20) begin
				rec.network_kind = php_pkg::NK_V4;
				rec.recognized = 1'b1;
				if (hw_n >= 4'd5) begin
					ev = 1'b1;
					l4f = o + {11'd0, hw_n, 2'b00};
				end
			end else if (vf == php_pkg::NK_V6 && len >= o + 17'd40) begin
				rec.network_kind = php_pkg::NK_V6;
				rec.recognized = 1'b1;
				ev = 1'b1;
				l4f = o + 17'd40;
			end
		end
		if (ev && l4f < len) begin
			case (np_n)
				php_pkg::PROTO_TCP: begin tk = php_pkg::TK_TCP; need = 17'd20; end
				php_pkg::PROTO_UDP: begin tk = php_pkg::TK_UDP; need = 17'd8; end
				php_pkg::PROTO_SCTP: begin tk = php_pkg::TK_SCTP; need = 17'd4; end
				php_pkg::PROTO_DCCP: begin tk = php_pkg::TK_DCCP; need = 17'd4; end
				default: tk = php_pkg::TK_NONE;
			endcase
			if (l4f + need > len) tk = php_pkg::TK_NONE;
		end
		rec.transport_kind = tk;
		rec.endpoints_valid = ev;
		if (ev) begin
			rec.source_high = ad_n[0];
			rec.source_low = ad_n[1];
			rec.destination_high = ad_n[2];
			rec.destination_low = ad_n[3];
		end
		if (tk != php_pkg::TK_NONE) begin
			rec.source_port = pt_n[0];
			rec.destination_port = pt_n[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ek_q <= '0;
			vn_q <= '0;
			hw_q <= '0;
			np_q <= '0;
			ad_q <= '{default: '0};
			pt_q <= '{default: '0};
		end else if (take) begin
			if (item.last_byte) begin
				pos_q <= '0;
				ek_q <= '0;
				vn_q <= '0;
				hw_q <= '0;
				np_q <= '0;
				ad_q <= '{default: '0};
				pt_q <= '{default: '0};
			end else begin
				if (pos_q < php_pkg::POS_W'(MAX_POSITION)) pos_q <= pos_q + 1'b1;
				ek_q <= ek_n;
				vn_q <= vn_n;
				hw_q <= hw_n;
				np_q <= np_n;
				ad_q <= ad_n;
				pt_q <= pt_n;
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/php_queue.sv
// Record queue between the capture front end and the output channel.
`default_nettype none
module php_queue #(
	parameter int DEPTH = php_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire php_pkg::record_t push_data,
	output logic                  full,
	output logic                  rec_valid,
	input  wire logic             rec_stall,
	output php_pkg::record_t      rec_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	php_pkg::record_t mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign rec_valid = (cnt_q != '0);
	assign rec_data = mem[rd_q];
	assign pop = rec_valid && !rec_stall;

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

>>> sv/packet_header_parser.sv
// Top level of the packet header parser.
// Usage:
//   byte channel (byte_valid/byte_stall/byte_data) takes one packet byte per
//   cycle unless stalled; last_byte marks the final captured byte, tag is copied.
//   rec channel (rec_valid/rec_stall/rec_data) gives one record per packet,
//   registered into the record queue when the last byte is taken.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes link_type; ready is
//   always high; write only while no packet is in flight.
// Throughput: one byte per cycle, limited only by the record queue
//   (QUEUE_DEPTH entries, default 2); byte_stall rises while it is full.
// Stall: when the receiver holds rec_stall, records wait in the queue and
//   bytes continue to flow until the queue fills.
// Reset: arst_n clears link_type to Ethernet, the byte position and all
//   captured fields, and empties the queue.
`default_nettype none
`include "assert_macros.svh"
module packet_header_parser #(
	parameter int MAX_POSITION = php_pkg::MAX_POSITION_DEF,
	parameter int QUEUE_DEPTH = php_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_data,
	input  wire logic                byte_valid,
	output logic                     byte_stall,
	input  wire php_pkg::byte_item_t byte_data,
	output logic                     rec_valid,
	input  wire logic                rec_stall,
	output php_pkg::record_t         rec_data
);
	logic [1:0] link_type_q;
	logic full, take;
	php_pkg::record_t front_rec;

	assign cfg_ready = 1'b1;
	assign byte_stall = full;
	assign take = byte_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) link_type_q <= php_pkg::LINK_ETH;
		else if (cfg_valid) link_type_q <= cfg_data;
	end

	php_front #(.MAX_POSITION(MAX_POSITION)) u_front (
		.clk(clk), .arst_n(arst_n), .link_type(link_type_q),
		.take(take), .item(byte_data), .rec(front_rec)
	);

	php_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(take && byte_data.last_byte),
		.push_data(front_rec), .full(full), .rec_valid(rec_valid),
		.rec_stall(rec_stall), .rec_data(rec_data)
	);

	`PHP_ASSERT_NXT(a_rec_after_last, take && byte_data.last_byte, rec_valid)
	`PHP_ASSERT_IMP(a_ports_zero, rec_valid && rec_data.transport_kind == php_pkg::TK_NONE, rec_data.source_port == 16'd0 && rec_data.destination_port == 16'd0)
	`PHP_ASSERT_IMP(a_addr_zero, rec_valid && !rec_data.endpoints_valid, rec_data.source_low == 64'd0 && rec_data.destination_low == 64'd0)
	`PHP_ASSERT_IMP(a_net_recog, rec_valid && rec_data.network_kind != php_pkg::NK_NONE, rec_data.recognized)
endmodule
`default_nettype wire
